FILE: hw/rtl/vlc_pkg.sv
`default_nettype none
package vlc_pkg;

    localparam int unsigned COMP_W = 16;
    localparam int unsigned SQ_W   = 2 * COMP_W;
    localparam int unsigned LANES  = 3;

    typedef logic signed [COMP_W-1:0] t_comp;

    // one slot of the square root pipeline
    typedef struct packed {
        logic              valid;
        logic              clamp;
        t_comp             x;
        t_comp             y;
        t_comp             z;
        logic [COMP_W-1:0] m;
        logic [SQ_W-1:0]   rem;
        logic [COMP_W-1:0] root;
    } t_sqrt_stage;

    // one slot of the divider pipeline, one lane per component
    typedef struct packed {
        logic                         valid;
        logic                         clamp;
        t_comp                        x;
        t_comp                        y;
        t_comp                        z;
        logic [LANES-1:0]             neg;
        logic [COMP_W-1:0]            len;
        logic [LANES-1:0][SQ_W-1:0]   rem;
        logic [LANES-1:0][COMP_W-1:0] quot;
    } t_div_stage;

endpackage
`default_nettype wire

FILE: hw/rtl/vlc_in_if.sv
`default_nettype none
interface vlc_in_if;
    logic                  valid;
    logic                  ready;
    vlc_pkg::t_comp        comp_x;
    vlc_pkg::t_comp        comp_y;
    vlc_pkg::t_comp        comp_z;

    modport source (output valid, output comp_x, output comp_y, output comp_z, input ready);
    modport sink   (input valid, input comp_x, input comp_y, input comp_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/vlc_out_if.sv
`default_nettype none
interface vlc_out_if;
    logic                  valid;
    logic                  ready;
    vlc_pkg::t_comp        out_x;
    vlc_pkg::t_comp        out_y;
    vlc_pkg::t_comp        out_z;
    logic                  was_clamped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output was_clamped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input was_clamped, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/vlc_sqrt.sv
`default_nettype none
// Pipelined floor square root, one result bit per stage.
module vlc_sqrt (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  vlc_pkg::t_sqrt_stage  i_stage,
    output vlc_pkg::t_sqrt_stage  o_stage
);
    localparam int unsigned NB = vlc_pkg::COMP_W;

    vlc_pkg::t_sqrt_stage r_stg [0:NB];
    vlc_pkg::t_sqrt_stage n_stg [0:NB];

    assign n_stg[0] = i_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg[0].valid <= 1'b0;
        end else if (i_en) begin
            r_stg[0] <= n_stg[0];
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_stage
        localparam int unsigned B = NB - 1 - g;
        logic [vlc_pkg::SQ_W+1:0] trial;

        // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
        assign trial = ({(vlc_pkg::SQ_W+2-NB)'(0), r_stg[g].root} << (B + 1))
                     + ((vlc_pkg::SQ_W+2)'(1) << (2 * B));

        always_comb begin
            n_stg[g+1] = r_stg[g];
            if ({2'b00, r_stg[g].rem} >= trial) begin
                n_stg[g+1].rem  = r_stg[g].rem - trial[vlc_pkg::SQ_W-1:0];
                n_stg[g+1].root = r_stg[g].root | (NB'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[g+1].valid <= 1'b0;
            end else if (i_en) begin
                r_stg[g+1] <= n_stg[g+1];
            end
        end
    end

    assign o_stage = r_stg[NB];
endmodule
`default_nettype wire

FILE: hw/rtl/vlc_div.sv
`default_nettype none
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Quotient is known to fit in COMP_W bits.
module vlc_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  vlc_pkg::t_div_stage  i_stage,
    output vlc_pkg::t_div_stage  o_stage
);
    localparam int unsigned NB = vlc_pkg::COMP_W;

    vlc_pkg::t_div_stage r_stg [0:NB-1];
    vlc_pkg::t_div_stage n_stg [0:NB-1];

    for (genvar g = 0; g < NB; g++) begin : g_stage
        localparam int unsigned B = NB - 1 - g;
        vlc_pkg::t_div_stage cur;
        logic [vlc_pkg::SQ_W:0] dvs;

        if (g == 0) begin : g_first
            assign cur = i_stage;
        end else begin : g_next
            assign cur = r_stg[g-1];
        end

        assign dvs = {(vlc_pkg::SQ_W+1-NB)'(0), cur.len} << B;

        always_comb begin
            n_stg[g] = cur;
            for (int k = 0; k < vlc_pkg::LANES; k++) begin
                if ({1'b0, cur.rem[k]} >= dvs) begin
                    n_stg[g].rem[k]  = cur.rem[k] - dvs[vlc_pkg::SQ_W-1:0];
                    n_stg[g].quot[k] = cur.quot[k] | (NB'(1) << B);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[g].valid <= 1'b0;
            end else if (i_en) begin
                r_stg[g] <= n_stg[g];
            end
        end
    end

    assign o_stage = r_stg[NB-1];
endmodule
`default_nettype wire

FILE: hw/rtl/vector_length_clamp.sv
`default_nettype none
// Clamps the Euclidean length of a signed Q8.8 3D vector to max_length (unsigned Q8.8,
// reset 65535). When the squared length exceeds max_length squared, each component is
// scaled by max_length / floor(sqrt(squared length)), truncated toward zero, and
// was_clamped is set; otherwise the vector passes unchanged. Fully pipelined: one
// transaction per cycle while the output accepts, through squares, sum/compare, 16
// square root stages, scale multiply, 16 divider stages and an output register. The
// whole pipeline advances together and holds while a result waits at the output. Write
// max_length only while no transaction is in flight.
module vector_length_clamp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire        [15:0] i_cfg_data,
    vlc_in_if.sink            i_in,
    vlc_out_if.source         o_out
);
    localparam int unsigned CW = vlc_pkg::COMP_W;
    localparam int unsigned SW = vlc_pkg::SQ_W;

    logic en;

    logic [CW-1:0]   r_max_len;

    logic            r_s1_valid;
    vlc_pkg::t_comp  r_s1_x, r_s1_y, r_s1_z;
    logic [CW-1:0]   r_s1_m;
    logic [SW-1:0]   r_s1_sqx, r_s1_sqy, r_s1_sqz, r_s1_msq;

    vlc_pkg::t_sqrt_stage sq_in, sq_out;
    vlc_pkg::t_div_stage  n_dv, r_dv, dv_out;

    logic [SW:0]     sum_sq;

    logic            r_out_valid;
    vlc_pkg::t_comp  r_out_x, r_out_y, r_out_z;
    logic            r_out_clamped;
    vlc_pkg::t_comp  n_out_x, n_out_y, n_out_z;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'hFFFF;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    // stage 1: squares (operands widened first so the products are full width)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in.valid;
            r_s1_x     <= i_in.comp_x;
            r_s1_y     <= i_in.comp_y;
            r_s1_z     <= i_in.comp_z;
            r_s1_m     <= r_max_len;
            r_s1_sqx   <= SW'(i_in.comp_x) * SW'(i_in.comp_x);
            r_s1_sqy   <= SW'(i_in.comp_y) * SW'(i_in.comp_y);
            r_s1_sqz   <= SW'(i_in.comp_z) * SW'(i_in.comp_z);
            r_s1_msq   <= SW'(r_max_len) * SW'(r_max_len);
        end
    end

    // stage 2: sum and compare, registered at the root pipeline entry
    assign sum_sq = {1'b0, r_s1_sqx} + {1'b0, r_s1_sqy} + {1'b0, r_s1_sqz};

    always_comb begin
        sq_in.valid = r_s1_valid;
        sq_in.clamp = sum_sq > {1'b0, r_s1_msq};
        sq_in.x     = r_s1_x;
        sq_in.y     = r_s1_y;
        sq_in.z     = r_s1_z;
        sq_in.m     = r_s1_m;
        sq_in.rem   = sum_sq[SW-1:0];
        sq_in.root  = '0;
    end

    vlc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (sq_in),
        .o_stage (sq_out)
    );

    // magnitude times max_length per lane
    always_comb begin
        logic [CW:0] mag_x, mag_y, mag_z;
        mag_x = sq_out.x[CW-1] ? -{1'b1, sq_out.x} : {1'b0, sq_out.x};
        mag_y = sq_out.y[CW-1] ? -{1'b1, sq_out.y} : {1'b0, sq_out.y};
        mag_z = sq_out.z[CW-1] ? -{1'b1, sq_out.z} : {1'b0, sq_out.z};
        n_dv.valid  = sq_out.valid;
        n_dv.clamp  = sq_out.clamp;
        n_dv.x      = sq_out.x;
        n_dv.y      = sq_out.y;
        n_dv.z      = sq_out.z;
        n_dv.neg    = {sq_out.z[CW-1], sq_out.y[CW-1], sq_out.x[CW-1]};
        n_dv.len    = sq_out.root;
        n_dv.rem[0] = SW'(mag_x[CW-1:0]) * SW'(sq_out.m);
        n_dv.rem[1] = SW'(mag_y[CW-1:0]) * SW'(sq_out.m);
        n_dv.rem[2] = SW'(mag_z[CW-1:0]) * SW'(sq_out.m);
        n_dv.quot   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.valid <= 1'b0;
        end else if (en) begin
            r_dv <= n_dv;
        end
    end

    vlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (r_dv),
        .o_stage (dv_out)
    );

    always_comb begin
        if (dv_out.clamp) begin
            n_out_x = dv_out.neg[0] ? -dv_out.quot[0] : dv_out.quot[0];
            n_out_y = dv_out.neg[1] ? -dv_out.quot[1] : dv_out.quot[1];
            n_out_z = dv_out.neg[2] ? -dv_out.quot[2] : dv_out.quot[2];
        end else begin
            n_out_x = dv_out.x;
            n_out_y = dv_out.y;
            n_out_z = dv_out.z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid   <= dv_out.valid;
            r_out_x       <= n_out_x;
            r_out_y       <= n_out_y;
            r_out_z       <= n_out_z;
            r_out_clamped <= dv_out.clamp;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_x       = r_out_x;
    assign o_out.out_y       = r_out_y;
    assign o_out.out_z       = r_out_z;
    assign o_out.was_clamped = r_out_clamped;
endmodule
`default_nettype wire
